// ----- hdl/aes3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes3_pkg
// Shared constants and types for the AES3 subframe biphase-mark encoder.
// ----------------------------------------------------------------------------
package aes3_pkg;

  // Frames per channel-status block
  localparam int unsigned FRAMES_PER_BLOCK = 192;

  // Preamble patterns, as sent after a low cell
  localparam logic [7:0] PRE_X = 8'b11100010;
  localparam logic [7:0] PRE_Y = 8'b11100100;
  localparam logic [7:0] PRE_Z = 8'b11101000;

  // Geometry of one subframe on the line
  localparam int unsigned AUDIO_W     = 24;
  localparam int unsigned SLOTS       = AUDIO_W + 4;   // audio + V U C P
  localparam int unsigned FRAME_BITS  = 64;            // eight bytes of cells
  localparam int unsigned BYTES       = FRAME_BITS / 8;
  localparam int unsigned BYTE_CNT_W  = $clog2(BYTES);
  localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(BYTES - 1);

  // Serializer status seen by the input side
  typedef struct packed {
    logic busy;       // a subframe is being sent
    logic can_load;   // a new subframe may be loaded this cycle
  } ser_status_t;

endpackage

// ----- hdl/aes3_enc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes3_enc_core
// Builds the 64 line cells of one subframe and tracks preamble state.
// ----------------------------------------------------------------------------
module aes3_enc_core
  import aes3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [AUDIO_W-1:0]    audio_sample,
  input  logic                  validity_bit,
  input  logic                  user_bit,
  input  logic                  chan_status_bit,
  output logic [FRAME_BITS-1:0] frame_bits
);

  localparam logic [8:0] FPB = 9'(FRAMES_PER_BLOCK);

  logic       last_cell_level_r, last_cell_level_nxt;
  logic       second_subframe_r, second_subframe_nxt;
  logic [7:0] frame_position_r,  frame_position_nxt;

  logic [SLOTS-1:0] data_bits;
  logic             parity;
  logic [7:0]       preamble;
  logic [8:0]       pos_inc;

  // Even parity over audio and status bits
  assign parity    = (^audio_sample) ^ validity_bit ^ user_bit ^ chan_status_bit;
  assign data_bits = {parity, chan_status_bit, user_bit, validity_bit, audio_sample};

  // Preamble choice, inverted after a high cell
  always_comb begin
    if (second_subframe_r) begin
      preamble = PRE_Y;
    end else if (frame_position_r == 8'd0) begin
      preamble = PRE_Z;
    end else begin
      preamble = PRE_X;
    end
    if (last_cell_level_r) begin
      preamble = ~preamble;
    end
  end

  // Biphase-mark cells: the level entering slot k depends on the ones before it
  always_comb begin
    logic [SLOTS-1:0] mask;
    logic             lvl;
    logic             first;
    frame_bits = '0;
    frame_bits[FRAME_BITS-1 -: 8] = preamble;
    for (int k = 0; k < SLOTS; k++) begin
      mask  = (SLOTS'(1) << k) - SLOTS'(1);
      lvl   = last_cell_level_r ^ k[0] ^ (^(data_bits & mask));
      first = ~lvl;
      frame_bits[FRAME_BITS-9-2*k] = first;
      frame_bits[FRAME_BITS-10-2*k] = first ^ data_bits[k];
    end
  end

  // State update when a subframe is handed on
  assign pos_inc = {1'b0, frame_position_r} + 9'd1;

  always_comb begin
    last_cell_level_nxt = last_cell_level_r;
    second_subframe_nxt = second_subframe_r;
    frame_position_nxt  = frame_position_r;
    if (advance) begin
      last_cell_level_nxt = frame_bits[0];
      second_subframe_nxt = ~second_subframe_r;
      if (second_subframe_r) begin
        frame_position_nxt = (pos_inc >= FPB) ? 8'd0 : pos_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cell_level_r <= 1'b0;
      second_subframe_r <= 1'b0;
      frame_position_r  <= 8'd0;
    end else begin
      last_cell_level_r <= last_cell_level_nxt;
      second_subframe_r <= second_subframe_nxt;
      frame_position_r  <= frame_position_nxt;
    end
  end

  // Subframes alternate between first and second
  a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (second_subframe_r != $past(second_subframe_r)))
    else $error("subframe parity did not toggle");

  // Position only moves after a second subframe
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !second_subframe_r) |=> $stable(frame_position_r))
    else $error("frame position moved after a first subframe");

  // Position stays inside the block
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, frame_position_r} < FPB))
    else $error("frame position outside the block");

endmodule

// ----- hdl/aes3_ser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes3_ser
// Result register: sends one subframe as eight bytes, one per accepted item.
// ----------------------------------------------------------------------------
module aes3_ser
  import aes3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic [FRAME_BITS-1:0] load_bits,
  output ser_status_t           status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_cell_byte,
  output logic                  out_last_of_subframe
);

  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [BYTE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  valid_r, valid_nxt;
  logic                  take;

  assign take            = valid_r && !out_stall;
  assign status.busy     = valid_r;
  assign status.can_load = !valid_r || (take && (cnt_r == LAST_BYTE));

  // Shift out one byte per accepted item, reload after the last one
  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    if (take) begin
      shift_nxt = {shift_r[FRAME_BITS-9:0], 8'h00};
      cnt_nxt   = cnt_r + BYTE_CNT_W'(1);
      if (cnt_r == LAST_BYTE) begin
        valid_nxt = 1'b0;
      end
    end
    if (load) begin
      shift_nxt = load_bits;
      cnt_nxt   = '0;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign out_valid            = valid_r;
  assign out_cell_byte        = shift_r[FRAME_BITS-1 -: 8];
  assign out_last_of_subframe = (cnt_r == LAST_BYTE);

  // Never overwrite a subframe that is still going out
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> status.can_load)
    else $error("load while bytes remain");

  // A load starts at the first byte
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (valid_r && cnt_r == '0))
    else $error("load did not start a subframe");

  // A stalled byte keeps its position
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |=> (valid_r && $stable(cnt_r)))
    else $error("byte position moved under stall");

endmodule

// ----- hdl/aes3_subframe_biphase_encoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes3_subframe_biphase_encoder_top
// AES3 subframe encoder: one subframe in, eight bytes of biphase-mark cells out.
// ----------------------------------------------------------------------------
// Path: a taken subframe waits in the input register until the serializer can load
//   it, then its first byte comes out of the serializer shift register.
// Throughput: the output port moves one byte per cycle while out_stall is low; the
//   input register takes the next subframe while bytes drain.
// Reset (rst_n, synchronous): empties both registers, next subframe is Z with
//   the line starting low.
module aes3_subframe_biphase_encoder_top
  import aes3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [AUDIO_W-1:0] in_audio_sample,
  input  logic               in_validity_bit,
  input  logic               in_user_bit,
  input  logic               in_chan_status_bit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_cell_byte,
  output logic               out_last_of_subframe
);

  logic               hold_valid_r, hold_valid_nxt;
  logic [AUDIO_W-1:0] audio_r;
  logic               v_r, u_r, c_r;
  logic               load;
  logic               in_take;
  ser_status_t        ser_status;
  logic [FRAME_BITS-1:0] frame_bits;

  // Input register: freed when its subframe moves into the serializer
  assign load     = hold_valid_r && ser_status.can_load;
  assign in_stall = hold_valid_r && !load;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (load) begin
      hold_valid_nxt = 1'b0;
    end
    if (in_take) begin
      hold_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      audio_r <= in_audio_sample;
      v_r     <= in_validity_bit;
      u_r     <= in_user_bit;
      c_r     <= in_chan_status_bit;
    end
  end

  aes3_enc_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (load),
    .audio_sample    (audio_r),
    .validity_bit    (v_r),
    .user_bit        (u_r),
    .chan_status_bit (c_r),
    .frame_bits      (frame_bits)
  );

  aes3_ser u_ser (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load                 (load),
    .load_bits            (frame_bits),
    .status               (ser_status),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_cell_byte        (out_cell_byte),
    .out_last_of_subframe (out_last_of_subframe)
  );

endmodule

// ----- sim/aes3_subframe_biphase_encoder_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes3_subframe_biphase_encoder_top_tb
// Self-checking bench for the AES3 subframe biphase-mark encoder. Subframes go
// in through a valid/stall driver. A line-coding model predicts the eight cell
// bytes of each subframe: preamble, audio, then V U C P. A monitor compares
// every byte taken from the output port. Directed corner words come first.
// Random subframes follow, under three idle patterns. Z, X and Y preambles and
// both line polarities are all exercised.
// ----------------------------------------------------------------------------
module aes3_subframe_biphase_encoder_top_tb;
  import aes3_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 68;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD_LEN   = 100;
  localparam int unsigned DRAIN_CYCLES    = 20;

  typedef struct packed {
    logic [AUDIO_W-1:0] audio;
    logic               v;
    logic               u;
    logic               c;
  } subframe_t;

  typedef struct packed {
    logic [7:0] cells;
    logic       last;
  } cell_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [AUDIO_W-1:0] in_audio_sample = '0;
  logic               in_validity_bit = 1'b0;
  logic               in_user_bit = 1'b0;
  logic               in_chan_status_bit = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_cell_byte;
  logic               out_last_of_subframe;

  subframe_t  subframe_q[$];
  cell_byte_t cell_q[$];

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 51;
  int unsigned subframes_taken = 0;
  int unsigned bytes_checked = 0;
  int unsigned z_preambles = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned long_hold_at = 0;
  logic        long_hold_done = 1'b0;

  // Line model state
  logic        line_level;
  logic        second_sub;
  int unsigned frame_pos;

  aes3_subframe_biphase_encoder_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_audio_sample      (in_audio_sample),
    .in_validity_bit      (in_validity_bit),
    .in_user_bit          (in_user_bit),
    .in_chan_status_bit   (in_chan_status_bit),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_cell_byte        (out_cell_byte),
    .out_last_of_subframe (out_last_of_subframe)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Biphase-mark cells for four bits, LSB first; advances the line level
  function automatic logic [7:0] bmc_cells(input logic [3:0] bits);
    logic [7:0] cells = '0;
    logic       lvl;
    logic       c0;
    logic       c1;
    lvl = line_level;
    for (int k = 0; k < 4; k++) begin
      c0 = ~lvl;
      c1 = bits[k] ? ~c0 : c0;
      cells = {cells[5:0], c0, c1};
      lvl = c1;
    end
    line_level = lvl;
    return cells;
  endfunction

  // Predict the eight cell bytes of one subframe
  function automatic void encode_subframe(input subframe_t sf);
    logic [7:0] pre;
    logic       par;
    cell_byte_t cb;
    if (second_sub) begin
      pre = PRE_Y;
    end else if (frame_pos == 0) begin
      pre = PRE_Z;
      z_preambles++;
    end else begin
      pre = PRE_X;
    end
    // preamble is inverted after a high cell and leaves the level unchanged
    cb.cells = pre ^ {8{line_level}};
    cb.last  = 1'b0;
    cell_q.push_back(cb);
    for (int i = 0; i < 6; i++) begin
      cb.cells = bmc_cells(sf.audio[4*i +: 4]);
      cb.last  = 1'b0;
      cell_q.push_back(cb);
    end
    par = ^sf.audio ^ sf.v ^ sf.u ^ sf.c;
    cb.cells = bmc_cells({par, sf.c, sf.u, sf.v});
    cb.last  = 1'b1;
    cell_q.push_back(cb);
    if (second_sub) begin
      frame_pos  = (frame_pos + 1 >= FRAMES_PER_BLOCK) ? 0 : frame_pos + 1;
      second_sub = 1'b0;
    end else begin
      second_sub = 1'b1;
    end
  endfunction

  task automatic queue_subframe(input logic [AUDIO_W-1:0] audio, input logic v,
                                input logic u, input logic c);
    subframe_t sf;
    sf.audio = audio;
    sf.v = v;
    sf.u = u;
    sf.c = c;
    subframe_q.push_back(sf);
  endtask

  // Wait until every queued subframe is taken and all its bytes are out
  task automatic wait_all_done();
    do @(negedge clk); while (subframe_q.size() != 0 || in_valid || cell_q.size() != 0);
  endtask

  // Input driver: holds an item until taken, then may idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      line_level = 1'b0;
      second_sub = 1'b0;
      frame_pos  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_subframe({in_audio_sample, in_validity_bit, in_user_bit,
                         in_chan_status_bit});
        subframes_taken <= subframes_taken + 1;
      end
      if (!in_valid || !in_stall) begin
        if (subframe_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          subframe_t sf;
          sf = subframe_q.pop_front();
          in_audio_sample    <= sf.audio;
          in_validity_bit    <= sf.v;
          in_user_bit        <= sf.u;
          in_chan_status_bit <= sf.c;
          in_valid           <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && long_hold_at != 0 && subframes_taken >= long_hold_at) begin
      out_stall      <= 1'b1;
      hold_left      <= LONG_HOLD_LEN;
      long_hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (cell_q.size() == 0) begin
        $display("%0t: unexpected byte: actual cells=%02h last=%0b", $time,
                 out_cell_byte, out_last_of_subframe);
        errors++;
      end else begin
        cell_byte_t exp_b;
        exp_b = cell_q.pop_front();
        if (out_cell_byte !== exp_b.cells) begin
          $display("%0t: cell_byte mismatch: expected %02h actual %02h", $time,
                   exp_b.cells, out_cell_byte);
          errors++;
        end
        if (out_last_of_subframe !== exp_b.last) begin
          $display("%0t: last_of_subframe mismatch: expected %0b actual %0b", $time,
                   exp_b.last, out_last_of_subframe);
          errors++;
        end
      end
      bytes_checked++;
    end
  end

  // Watchdog on cycles with no transfer on either port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("aes3_subframe_biphase_encoder_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: all-zero/all-one words, single end bits, patterns, parity
    queue_subframe(24'h000000, 1'b0, 1'b0, 1'b0);
    queue_subframe(24'hFFFFFF, 1'b1, 1'b1, 1'b1);
    queue_subframe(24'h000001, 1'b0, 1'b0, 1'b0);
    queue_subframe(24'h800000, 1'b0, 1'b0, 1'b0);
    queue_subframe(24'h555555, 1'b1, 1'b0, 1'b0);
    queue_subframe(24'hAAAAAA, 1'b0, 1'b1, 1'b0);
    queue_subframe(24'h000000, 1'b0, 1'b0, 1'b1);
    queue_subframe(24'hFFFFFF, 1'b0, 1'b0, 1'b0);
    queue_subframe(24'h123456, 1'b1, 1'b1, 1'b0);
    queue_subframe(24'hFEDCBA, 1'b0, 1'b1, 1'b1);
    queue_subframe(24'h000000, 1'b1, 1'b1, 1'b1);
    queue_subframe(24'h7FFFFF, 1'b1, 1'b0, 1'b1);
    queue_subframe(24'h0F0F0F, 1'b0, 1'b0, 1'b0);
    queue_subframe(24'hF0F0F0, 1'b1, 1'b1, 1'b1);
    queue_subframe(24'h000003, 1'b1, 1'b0, 1'b0);
    queue_subframe(24'h800001, 1'b0, 1'b0, 1'b1);
    wait_all_done();

    // Random phases; the sender pauses for a full drain between them
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          long_hold_at  = subframes_taken + 10;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        queue_subframe(AUDIO_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end
      wait_all_done();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (cell_q.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, cell_q.size());
      errors++;
    end
    $display("Run covered %0d subframes and %0d cell bytes, %0d Z preambles.",
             subframes_taken, bytes_checked, z_preambles);
    if (errors == 0) begin
      $display("aes3_subframe_biphase_encoder_top test passed");
    end else begin
      $display("aes3_subframe_biphase_encoder_top test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/aes3_pkg.sv
hdl/aes3_enc_core.sv
hdl/aes3_ser.sv
hdl/aes3_subframe_biphase_encoder_top.sv
sim/aes3_subframe_biphase_encoder_top_tb.sv
